FILE: sv/gzhtc_pkg.sv
// constants and helper functions for the gzip member header/trailer checker
// no dependencies

package gzhtc_pkg;

  localparam int unsigned PH_W = 4;

  localparam logic [PH_W-1:0] PH_FIXED   = 4'd0;
  localparam logic [PH_W-1:0] PH_XLEN    = 4'd1;
  localparam logic [PH_W-1:0] PH_EXTRA   = 4'd2;
  localparam logic [PH_W-1:0] PH_NAME    = 4'd3;
  localparam logic [PH_W-1:0] PH_COMMENT = 4'd4;
  localparam logic [PH_W-1:0] PH_HCRC    = 4'd5;
  localparam logic [PH_W-1:0] PH_DATA    = 4'd6;
  localparam logic [PH_W-1:0] PH_TRAILER = 4'd7;
  localparam logic [PH_W-1:0] PH_DONE    = 4'd8;

  localparam int unsigned FL_HCRC    = 1;
  localparam int unsigned FL_EXTRA   = 2;
  localparam int unsigned FL_NAME    = 3;
  localparam int unsigned FL_COMMENT = 4;

  localparam logic [1:0] REQ_HDR  = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_EOD  = 2'd2;
  localparam logic [1:0] REQ_EOI  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MAGIC     = 3'd1;
  localparam logic [2:0] ST_HCRC      = 3'd2;
  localparam logic [2:0] ST_DCRC      = 3'd3;
  localparam logic [2:0] ST_SIZE      = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;
  localparam logic [2:0] ST_MISPLACED = 3'd6;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [15:0] GZ_MAGIC = 16'h8B1F;

  typedef logic [PH_W-1:0] phase_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] x;
    x = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  // next optional header section after the given one
  function automatic phase_t next_hdr_phase(input phase_t after, input logic [7:0] fl);
    phase_t p;
    if (after < PH_XLEN && fl[FL_EXTRA]) begin
      p = PH_XLEN;
    end else if (after < PH_NAME && fl[FL_NAME]) begin
      p = PH_NAME;
    end else if (after < PH_COMMENT && fl[FL_COMMENT]) begin
      p = PH_COMMENT;
    end else if (after < PH_HCRC && fl[FL_HCRC]) begin
      p = PH_HCRC;
    end else begin
      p = PH_DATA;
    end
    return p;
  endfunction

endpackage

FILE: sv/gzip_member_header_trailer_checker.sv
// gzip member header/trailer checker: parses header, runs crc-32 and size check
// depends on gzhtc_pkg
//
//   port group  dir  handshake          payload
//   in_         in   in_valid/in_stall  in_req_type[1:0], in_data_byte[7:0]
//   out_        out  out_valid/out_stall out_status, out_header_done, out_stream_done,
//                                       out_crc_now
//
// one beat per cycle sustained while out_stall is low; each accepted beat passes through
// the input register, then one byte-wide crc-32 update and parse step into the result register
// rst_n is synchronous, active low; all parse state returns to the fixed-header phase
// an out_stall holds the result register and backs up to in_stall in the same cycle

module gzip_member_header_trailer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_header_done,
  output logic        out_stream_done,
  output logic [31:0] out_crc_now
);
  import gzhtc_pkg::*;

  logic        s1_valid_r;
  logic [1:0]  s1_req_r;
  logic [7:0]  s1_byte_r;
  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic        out_header_done_r;
  logic        out_stream_done_r;
  logic [31:0] out_crc_now_r;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  flag_r, flag_nxt;
  logic [15:0] extra_r, extra_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] size_r, size_nxt;
  logic [63:0] gather_r, gather_nxt;
  logic [2:0]  err_r, err_nxt;

  logic        out_free;
  logic        proc;
  logic [3:0]  count_inc;
  logic [63:0] gath;
  logic [31:0] crc_b;
  logic        enter_en;
  phase_t      enter_ph;

  assign out_free = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  assign count_inc = count_r + 4'd1;
  assign gath      = gather_r | ({56'd0, s1_byte_r} << {count_r[2:0], 3'b000});
  assign crc_b     = crc_byte(crc_r, s1_byte_r);

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    flag_nxt   = flag_r;
    extra_nxt  = extra_r;
    crc_nxt    = crc_r;
    size_nxt   = size_r;
    gather_nxt = gather_r;
    err_nxt    = err_r;
    enter_en   = 1'b0;
    enter_ph   = phase_r;
    if (err_r == ST_OK) begin
      case (s1_req_r)
        REQ_HDR: begin
          case (phase_r)
            PH_FIXED: begin
              crc_nxt    = crc_b;
              gather_nxt = gath;
              count_nxt  = count_inc;
              if (count_r == 4'd3) flag_nxt = s1_byte_r;
              if (count_inc == 4'd2 && gath[15:0] != GZ_MAGIC) begin
                err_nxt = ST_MAGIC;
              end else if (count_inc >= 4'd10) begin
                enter_en = 1'b1;
                enter_ph = next_hdr_phase(PH_FIXED, flag_nxt);
              end
            end
            PH_XLEN: begin
              crc_nxt    = crc_b;
              gather_nxt = gath;
              count_nxt  = count_inc;
              if (count_inc >= 4'd2) begin
                extra_nxt = gath[15:0];
                enter_en  = 1'b1;
                enter_ph  = (gath[15:0] == 16'd0) ? next_hdr_phase(PH_EXTRA, flag_r) : PH_EXTRA;
              end
            end
            PH_EXTRA: begin
              crc_nxt   = crc_b;
              extra_nxt = extra_r - 16'd1;
              if (extra_nxt == 16'd0) begin
                enter_en = 1'b1;
                enter_ph = next_hdr_phase(PH_EXTRA, flag_r);
              end
            end
            PH_NAME, PH_COMMENT: begin
              crc_nxt = crc_b;
              if (s1_byte_r == 8'd0) begin
                enter_en = 1'b1;
                enter_ph = next_hdr_phase(phase_r, flag_r);
              end
            end
            PH_HCRC: begin
              gather_nxt = gath;
              count_nxt  = count_inc;
              if (count_inc >= 4'd2) begin
                if (gath[15:0] != ~crc_r[15:0]) begin
                  err_nxt = ST_HCRC;
                end else begin
                  enter_en = 1'b1;
                  enter_ph = PH_DATA;
                end
              end
            end
            PH_TRAILER: begin
              gather_nxt = gath;
              count_nxt  = count_inc;
              if (count_inc >= 4'd8) begin
                if (gath[31:0] != ~crc_r) begin
                  err_nxt = ST_DCRC;
                end else if (gath[63:32] != size_r) begin
                  err_nxt = ST_SIZE;
                end else begin
                  phase_nxt = PH_DONE;
                end
              end
            end
            default: begin
              err_nxt = ST_MISPLACED;
            end
          endcase
        end
        REQ_DATA: begin
          if (phase_r == PH_DATA) begin
            crc_nxt  = crc_b;
            size_nxt = size_r + 32'd1;
          end else begin
            err_nxt = ST_MISPLACED;
          end
        end
        REQ_EOD: begin
          if (phase_r == PH_DATA) begin
            enter_en = 1'b1;
            enter_ph = PH_TRAILER;
          end else begin
            err_nxt = ST_MISPLACED;
          end
        end
        default: begin
          if (phase_r != PH_DONE) err_nxt = ST_TRUNC;
        end
      endcase
    end
    if (enter_en) begin
      phase_nxt  = enter_ph;
      count_nxt  = 4'd0;
      gather_nxt = 64'd0;
      if (enter_ph == PH_DATA) crc_nxt = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_FIXED;
      count_r     <= 4'd0;
      flag_r      <= 8'd0;
      extra_r     <= 16'd0;
      crc_r       <= CRC_INIT;
      size_r      <= 32'd0;
      gather_r    <= 64'd0;
      err_r       <= ST_OK;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (out_free) out_valid_r <= s1_valid_r;
      if (proc) begin
        phase_r  <= phase_nxt;
        count_r  <= count_nxt;
        flag_r   <= flag_nxt;
        extra_r  <= extra_nxt;
        crc_r    <= crc_nxt;
        size_r   <= size_nxt;
        gather_r <= gather_nxt;
        err_r    <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_r  <= in_req_type;
      s1_byte_r <= in_data_byte;
    end
    if (proc) begin
      out_status_r      <= err_nxt;
      out_header_done_r <= (phase_nxt >= PH_DATA);
      out_stream_done_r <= (phase_nxt == PH_DONE);
      out_crc_now_r     <= ~crc_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_header_done = out_header_done_r;
  assign out_stream_done = out_stream_done_r;
  assign out_crc_now     = out_crc_now_r;

`ifndef SYNTHESIS
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != ST_OK) |=> (err_r == $past(err_r)))
    else $error("latched error changed");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_DONE)
    else $error("parse phase out of range");

  a_done_implies_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stream_done_r) |-> out_header_done_r)
    else $error("stream done without header done");

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a full pipe");
`endif

endmodule
